/* sv/pnv_pkg.sv */
// Shared types and constants for the phone number validator.
// Holds character codes, number type codes, the automaton state type and the
// structs passed between the classifier, the scanner and the top level.
`default_nettype none

package pnv_pkg;

	localparam int CHAR_W            = 16;
	localparam int TYPE_W            = 3;
	localparam int COUNT_W           = 6;
	localparam int MAX_DIGITS_DEF    = 48;
	localparam int BRACKET_BITS_DEF  = 8;

	// Number type register codes; codes above NT_UNKNOWN are treated as unknown.
	localparam logic [TYPE_W-1:0] NT_PLAIN   = 3'd0;
	localparam logic [TYPE_W-1:0] NT_CONTACT = 3'd1;
	localparam logic [TYPE_W-1:0] NT_CLIENT  = 3'd2;
	localparam logic [TYPE_W-1:0] NT_SMS     = 3'd3;
	localparam logic [TYPE_W-1:0] NT_UNKNOWN = 3'd4;

	localparam logic [CHAR_W-1:0] CH_PLUS   = 16'h002B;
	localparam logic [CHAR_W-1:0] CH_OPEN   = 16'h0028;
	localparam logic [CHAR_W-1:0] CH_CLOSE  = 16'h0029;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 16'h002D;
	localparam logic [CHAR_W-1:0] CH_DOT    = 16'h002E;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 16'h002F;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_NINE   = 16'h0039;
	localparam logic [CHAR_W-1:0] CH_STAR   = 16'h002A;
	localparam logic [CHAR_W-1:0] CH_HASH   = 16'h0023;
	localparam logic [CHAR_W-1:0] CH_P      = 16'h0070;
	localparam logic [CHAR_W-1:0] CH_W      = 16'h0077;

	typedef enum logic [2:0] {
		ST_START,
		ST_GRP_DIG,
		ST_GRP_SEP,
		ST_PLUS,
		ST_STAR,
		ST_DIG,
		ST_SEP,
		ST_PSTAR
	} fsa_state_t;

	typedef struct packed {
		logic allowed;
		logic white;
		logic dot;
		logic digit;
		logic plus;
		logic open;
		logic close;
		logic sep;
		logic star_hash;
	} char_class_t;

	typedef struct packed {
		logic               is_valid;
		logic [COUNT_W-1:0] digit_total;
	} verdict_t;

endpackage

`default_nettype wire

/* sv/pnv_classify.sv */
// Character classifier for the phone number validator.
// Decodes one 16-bit character against the configured number type; uses pnv_pkg.
`default_nettype none

module pnv_classify
	import pnv_pkg::*;
(
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [TYPE_W-1:0] number_type,
	output char_class_t            cls
);

	logic white, digit, basic, extra, known;

	always_comb begin
		white = (char_code == 16'h0020) ||
			(char_code >= 16'h0009 && char_code <= 16'h000D) ||
			(char_code == 16'h0085) || (char_code == 16'h00A0) ||
			(char_code == 16'h1680) ||
			(char_code >= 16'h2000 && char_code <= 16'h200A) ||
			(char_code == 16'h2028) || (char_code == 16'h2029) ||
			(char_code == 16'h202F) || (char_code == 16'h205F) ||
			(char_code == 16'h3000);
		digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		basic = digit || (char_code == CH_PLUS) || (char_code == CH_OPEN) ||
			(char_code == CH_CLOSE) || (char_code == CH_MINUS) ||
			(char_code == CH_DOT) || (char_code == CH_SLASH);
		known = (number_type <= NT_SMS);
		// Contact and client types add the dialling characters, SMS only the star.
		extra = 1'b0;
		if (number_type == NT_CONTACT || number_type == NT_CLIENT) begin
			extra = (char_code == CH_P) || (char_code == CH_W) ||
				(char_code == CH_HASH) || (char_code == CH_STAR);
		end else if (number_type == NT_SMS) begin
			extra = (char_code == CH_STAR);
		end

		cls.allowed   = known && (white || basic || extra);
		cls.white     = white;
		cls.dot       = (char_code == CH_DOT);
		cls.digit     = digit;
		cls.plus      = (char_code == CH_PLUS);
		cls.open      = (char_code == CH_OPEN);
		cls.close     = (char_code == CH_CLOSE);
		cls.sep       = (char_code == CH_MINUS) || (char_code == CH_P) ||
			(char_code == CH_W) || (char_code == CH_SLASH);
		cls.star_hash = (char_code == CH_STAR) || (char_code == CH_HASH);
	end

endmodule

`default_nettype wire

/* sv/pnv_scan.sv */
// String scanner for the phone number validator: automaton, digit and
// bracket counters, failure latch and the end-of-string verdict. Uses pnv_pkg.
`default_nettype none

module pnv_scan
	import pnv_pkg::*;
#(
	parameter int MAX_DIGITS   = MAX_DIGITS_DEF,
	parameter int BRACKET_BITS = BRACKET_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        last,
	input  wire char_class_t cls,
	output verdict_t         verdict
);

	localparam logic [COUNT_W-1:0] CNT_SAT = COUNT_W'(MAX_DIGITS + 1);
	localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'(MAX_DIGITS);
	localparam logic signed [BRACKET_BITS-1:0] BAL_HI = {1'b0, {(BRACKET_BITS-1){1'b1}}};
	localparam logic signed [BRACKET_BITS-1:0] BAL_LO = {1'b1, {(BRACKET_BITS-1){1'b0}}};

	fsa_state_t                     state_q, state_nx, fsa_nx;
	logic [COUNT_W-1:0]             count_q, count_nx;
	logic signed [BRACKET_BITS-1:0] bal_q, bal_nx;
	logic                           failed_q, failed_nx;
	logic                           first_q;
	logic                           fsa_ok;

	// Automaton step for a character that reaches it.
	always_comb begin
		fsa_nx = state_q;
		fsa_ok = 1'b1;
		unique case (state_q)
			ST_START: begin
				if (cls.plus) fsa_nx = ST_PLUS;
				else if (cls.digit) fsa_nx = ST_DIG;
				else if (cls.star_hash) fsa_nx = ST_STAR;
				else fsa_ok = 1'b0;
			end
			ST_GRP_DIG: begin
				if (cls.sep) fsa_nx = ST_GRP_SEP;
				else if (cls.star_hash) fsa_nx = ST_STAR;
				else if (cls.digit) fsa_nx = ST_GRP_DIG;
				else fsa_ok = 1'b0;
			end
			ST_GRP_SEP: begin
				if (cls.digit) fsa_nx = ST_GRP_DIG;
				else fsa_ok = 1'b0;
			end
			ST_PLUS: begin
				if (cls.digit) fsa_nx = ST_DIG;
				else if (cls.star_hash) fsa_nx = ST_PSTAR;
				else fsa_ok = 1'b0;
			end
			ST_STAR: begin
				if (cls.digit) fsa_nx = ST_GRP_DIG;
				else if (cls.star_hash) fsa_nx = ST_STAR;
				else fsa_ok = 1'b0;
			end
			ST_DIG: begin
				if (cls.sep) fsa_nx = ST_SEP;
				else if (cls.star_hash) fsa_nx = ST_PSTAR;
				else if (cls.digit) fsa_nx = ST_DIG;
				else fsa_ok = 1'b0;
			end
			ST_SEP: begin
				if (cls.digit) fsa_nx = ST_DIG;
				else fsa_ok = 1'b0;
			end
			ST_PSTAR: begin
				if (cls.star_hash) fsa_nx = ST_PSTAR;
				else if (cls.digit) fsa_nx = ST_DIG;
				else fsa_ok = 1'b0;
			end
			default: fsa_ok = 1'b0;
		endcase
	end

	// Once failed, nothing changes until the end of the string.
	always_comb begin
		state_nx  = state_q;
		count_nx  = count_q;
		bal_nx    = bal_q;
		failed_nx = failed_q;
		if (!failed_q) begin
			priority if (!cls.allowed) begin
				failed_nx = 1'b1;
			end else if (cls.white || cls.dot) begin
				failed_nx = 1'b0;
			end else if (cls.open) begin
				if (last || bal_q == BAL_HI) failed_nx = 1'b1;
				else bal_nx = bal_q + 1'b1;
			end else if (cls.close) begin
				if (first_q || bal_q == BAL_LO) failed_nx = 1'b1;
				else bal_nx = bal_q - 1'b1;
			end else begin
				if (cls.digit && count_q < CNT_SAT) count_nx = count_q + 1'b1;
				if (fsa_ok) state_nx = fsa_nx;
				else failed_nx = 1'b1;
			end
		end
	end

	always_comb begin
		verdict.digit_total = count_nx;
		verdict.is_valid = !failed_nx && (count_nx != '0) && (count_nx <= CNT_MAX) &&
			(state_nx == ST_GRP_DIG || state_nx == ST_DIG || state_nx == ST_PSTAR) &&
			(bal_nx == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_START;
			count_q  <= '0;
			bal_q    <= '0;
			failed_q <= 1'b0;
			first_q  <= 1'b1;
		end else if (step) begin
			first_q <= last;
			if (last) begin
				state_q  <= ST_START;
				count_q  <= '0;
				bal_q    <= '0;
				failed_q <= 1'b0;
			end else begin
				state_q  <= state_nx;
				count_q  <= count_nx;
				bal_q    <= bal_nx;
				failed_q <= failed_nx;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_SAT)
		else $error("digit count beyond saturation value");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last) |=> (first_q && !failed_q && count_q == '0 && bal_q == '0))
		else $error("scanner state not cleared after last character");

	a_fail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !last && failed_q) |=> failed_q)
		else $error("failure flag dropped inside a string");

endmodule

`default_nettype wire

/* sv/phone_number_validator_unit.sv */
// Top level of the phone number validator: input register, number type
// register, result register and the two handshakes. Uses pnv_pkg, pnv_classify, pnv_scan.
//
//   Channel | Signals                                   | Moves
//   char    | char_valid, char_stall, char_code, last_char | one character word
//   result  | result_valid, result_stall, is_valid, digit_total | one verdict word
//   config  | cfg_write, cfg_data                       | number type register
//
// A character word is taken every cycle unless char_stall holds it back; it waits in the input
// register while the scanner updates its counters and automaton from it.
// The verdict of a last character passes from the input register into the result register,
// which raises result_valid; the word waits in the input register while an earlier result stalls.
// Reset clears the scanner, the number type and both valid flags at once.
// Only a last character waiting on a stalled result holds the input side back.
`default_nettype none

module phone_number_validator_unit
	import pnv_pkg::*;
#(
	parameter int MAX_DIGITS   = MAX_DIGITS_DEF,
	parameter int BRACKET_BITS = BRACKET_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [TYPE_W-1:0]  cfg_data,
	input  wire logic               char_valid,
	output logic                    char_stall,
	input  wire logic [CHAR_W-1:0]  char_code,
	input  wire logic               last_char,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic                    is_valid,
	output logic [COUNT_W-1:0]      digit_total
);

	logic [TYPE_W-1:0] number_type_q;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              vld_s1;
	logic              result_valid_q;
	logic              is_valid_q;
	logic [COUNT_W-1:0] digit_total_q;
	logic              out_free, s1_go, in_take;
	char_class_t       cls;
	verdict_t          verdict;

	// A word that is not last needs no result slot, so it always moves on.
	assign out_free   = !result_valid_q || !result_stall;
	assign s1_go      = vld_s1 && (!last_s1 || out_free);
	assign char_stall = vld_s1 && !s1_go;
	assign in_take    = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_type_q <= NT_PLAIN;
		end else if (cfg_write) begin
			number_type_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (s1_go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	pnv_classify u_classify (
		.char_code   (char_s1),
		.number_type (number_type_q),
		.cls         (cls)
	);

	pnv_scan #(
		.MAX_DIGITS   (MAX_DIGITS),
		.BRACKET_BITS (BRACKET_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_go),
		.last    (last_s1),
		.cls     (cls),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			is_valid_q    <= verdict.is_valid;
			digit_total_q <= verdict.digit_total;
		end
	end

	assign result_valid = result_valid_q;
	assign is_valid     = is_valid_q;
	assign digit_total  = digit_total_q;

	a_verdict_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> result_valid_q)
		else $error("last character did not produce a verdict");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> (vld_s1 && last_s1 && result_valid_q && result_stall))
		else $error("input stalled without a blocked verdict");

	a_valid_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && is_valid_q) |->
			(digit_total_q != '0 && digit_total_q <= COUNT_W'(MAX_DIGITS)))
		else $error("valid verdict with digit total out of range");

endmodule

`default_nettype wire
